/* rtl/sctab_pkg.sv */
package sctab_pkg;

    localparam int DB_W  = 8;
    localparam int KEY_W = 64;
    localparam int CNT_W = 64;
    localparam int TICK_W = 32;
    localparam int ENTRY_W = DB_W + KEY_W + CNT_W;

    localparam logic [TICK_W-1:0] PERIOD_RESET = 32'd3600;
    localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic [DB_W-1:0]  db_id;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

/* rtl/sctab_ram.sv */
module sctab_ram #(
    parameter int WIDTH = 136,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/saturating_credit_counter_table.sv */
// Table of up to CAPACITY saturating credit counters tagged by (db_id, key).
// Entries live in one synchronous memory, filled in order from slot 0, and
// a fill count marks which slots are live, so a periodic clear takes no
// memory pass and the block is ready right after reset. A counter access
// walks the live entries one per cycle through the single memory read
// port, stopping at the first match; on an empty table it skips the walk.
// A finished result waits in the output register, and the next item is
// taken while it waits; a later result waits until the register is free.
module saturating_credit_counter_table
    import sctab_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_wdata,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [DB_W-1:0]   i_db_id,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [CNT_W-1:0]  i_amount,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_found,
    output logic              o_dropped
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int USED_W = $clog2(CAPACITY + 1);
    localparam logic [USED_W-1:0] CAP_U = USED_W'(CAPACITY);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [USED_W-1:0]  r_used, n_used;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [TICK_W-1:0]  r_period;
    logic               r_out_valid, n_out_valid;
    logic               r_hit, n_hit;

    logic [DB_W-1:0]    r_db;
    logic [KEY_W-1:0]   r_key;
    logic [CNT_W-1:0]   r_amount;
    logic [CNT_W-1:0]   r_old, n_old;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_found, n_found;
    logic               r_dropped, n_dropped;

    logic               accept;
    logic               load_out;
    logic [IDX_W-1:0]   rd_addr;
    t_entry             rd_entry;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic [USED_W-1:0]  idx_next;
    logic [TICK_W-1:0]  tick_inc;
    logic               tick_clear;
    logic [CNT_W:0]     sum;
    logic [CNT_W-1:0]   sat_sum;
    logic               amt_zero;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    assign idx_next   = USED_W'(r_idx) + USED_W'(1);
    assign rd_addr    = (r_state == S_SCAN) ? r_idx + IDX_W'(1) : '0;
    assign tick_inc   = r_tick + TICK_W'(1);
    assign tick_clear = (tick_inc >= r_period) || (tick_inc == '0);
    assign sum        = {1'b0, r_old} + {1'b0, r_amount};
    assign sat_sum    = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    assign amt_zero   = (r_amount == '0);

    sctab_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_used      = r_used;
        n_tick      = r_tick;
        n_hit       = r_hit;
        n_old       = r_old;
        n_count     = r_count;
        n_found     = r_found;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && i_out_stall;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = '{db_id: r_db, key: r_key, count: sat_sum};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_TICK) begin
                        if (tick_clear) begin
                            n_tick = '0;
                            n_used = '0;
                        end else begin
                            n_tick = tick_inc;
                        end
                    end else begin
                        n_idx = '0;
                        n_hit = 1'b0;
                        n_state = (r_used == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_entry.db_id == r_db && rd_entry.key == r_key) begin
                    n_hit   = 1'b1;
                    n_old   = rd_entry.count;
                    n_state = S_DONE;
                end else if (idx_next == r_used) begin
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out  = 1'b1;
                    n_state   = S_IDLE;
                    n_found   = r_hit;
                    n_dropped = 1'b0;
                    if (r_hit) begin
                        n_count = amt_zero ? r_old : sat_sum;
                        mem_we  = !amt_zero;
                    end else if (amt_zero) begin
                        n_count = '0;
                    end else if (r_used < CAP_U) begin
                        n_count   = r_amount;
                        mem_we    = 1'b1;
                        mem_waddr = r_used[IDX_W-1:0];
                        mem_wdata = '{db_id: r_db, key: r_key, count: r_amount};
                        n_used    = r_used + USED_W'(1);
                    end else begin
                        n_count   = '0;
                        n_dropped = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_tick      <= '0;
            r_period    <= PERIOD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_db     <= i_db_id;
            r_key    <= i_key;
            r_amount <= i_amount;
        end
        r_idx     <= n_idx;
        r_hit     <= n_hit;
        r_old     <= n_old;
        r_count   <= n_count;
        r_found   <= n_found;
        r_dropped <= n_dropped;
    end

    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;
    assign o_found     = r_found;
    assign o_dropped   = r_dropped;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CAP_U)
        else $error("fill count above capacity");

    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> USED_W'(r_idx) < r_used)
        else $error("scan index past live entries");

    a_access_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_kind == KIND_ACCESS |=> o_in_stall)
        else $error("access did not start a lookup");

    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_kind == KIND_TICK && !r_out_valid |=> !o_out_valid)
        else $error("tick produced a result");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> !o_found && o_count == '0)
        else $error("dropped result carries data");

endmodule
